>>> hw/rtl/drt_pkg.sv
// Shared types, constants and helpers for the dirty rectangle tracker.
// Used by drt_fit and dirty_rectangle_tracker; depends on nothing.
package drt_pkg;

  localparam int TILE_COUNT   = 64;
  localparam int REGION_SLOTS = 6;
  localparam int LEVELS       = 2;
  localparam int BODY_SLOTS   = REGION_SLOTS - 2;
  localparam int STRIP_RIGHT  = REGION_SLOTS - 2;
  localparam int STRIP_BOTTOM = REGION_SLOTS - 1;

  localparam int COORD_W = 7;
  localparam int SEQ_W   = 32;
  localparam int CNT_W   = 7;
  localparam int SLOT_W  = $clog2(REGION_SLOTS);
  localparam int ROWS    = LEVELS * TILE_COUNT;
  localparam int ROW_AW  = $clog2(ROWS);
  localparam int SPAN_W  = COORD_W + 2;
  localparam int AREA_W  = 2 * SPAN_W;

  localparam logic       OP_MARK    = 1'b0;
  localparam logic       OP_DRAIN   = 1'b1;
  localparam logic [1:0] TGT_BODY   = 2'd0;
  localparam logic [1:0] TGT_RIGHT  = 2'd1;
  localparam logic [1:0] TGT_BOTTOM = 2'd2;
  localparam logic [1:0] TGT_NONE   = 2'd3;
  localparam logic [1:0] KIND_MARK   = 2'd0;
  localparam logic [1:0] KIND_REGION = 2'd1;
  localparam logic [1:0] KIND_CLEAN  = 2'd2;

  typedef struct packed {
    logic               op;
    logic [0:0]         level;
    logic [5:0]         tile;
    logic [1:0]         target;
    logic [COORD_W-1:0] rect_x0;
    logic [COORD_W-1:0] rect_y0;
    logic [COORD_W-1:0] rect_x1;
    logic [COORD_W-1:0] rect_y1;
    logic [SEQ_W-1:0]   commit_number;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         slot;
    logic [COORD_W-1:0] out_x0;
    logic [COORD_W-1:0] out_y0;
    logic [COORD_W-1:0] out_x1;
    logic [COORD_W-1:0] out_y1;
    logic               became_dirty;
    logic [SEQ_W-1:0]   oldest_commit;
    logic [CNT_W-1:0]   dirty_tiles;
    logic               last;
  } out_t;

  typedef struct packed {
    logic               dirty;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
  } rect_t;

  // One memory row holds a whole tile: its flag, first commit and all slots.
  typedef struct packed {
    logic                          tdirty;
    logic [SEQ_W-1:0]              first;
    rect_t [REGION_SLOTS-1:0]      slots;
  } row_t;

  typedef struct packed {
    logic  fits;
    rect_t uni;
  } fit_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_PLACE,
    ST_FLAG,
    ST_DRAIN,
    ST_EMIT,
    ST_RESP
  } state_t;

  // Signed area of an inclusive rectangle; inverted on one axis it goes zero or negative.
  function automatic logic signed [AREA_W-1:0] rect_area(input rect_t r);
    logic signed [SPAN_W-1:0] dx;
    logic signed [SPAN_W-1:0] dy;
    dx = $signed({2'b00, r.x1}) - $signed({2'b00, r.x0}) + $signed(SPAN_W'(1));
    dy = $signed({2'b00, r.y1}) - $signed({2'b00, r.y0}) + $signed(SPAN_W'(1));
    rect_area = dx * dy;
  endfunction

  // Bounding box of two rectangles, marked dirty.
  function automatic rect_t rect_union(input rect_t a, input rect_t b);
    rect_t u;
    u.dirty = 1'b1;
    u.x0 = (a.x0 < b.x0) ? a.x0 : b.x0;
    u.y0 = (a.y0 < b.y0) ? a.y0 : b.y0;
    u.x1 = (a.x1 > b.x1) ? a.x1 : b.x1;
    u.y1 = (a.y1 > b.y1) ? a.y1 : b.y1;
    rect_union = u;
  endfunction

endpackage

>>> hw/rtl/drt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module drt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/drt_fit.sv
// Merge test of one body slot against the incoming rectangle.
// Depends on drt_pkg (rect_t, fit_t, rect_area, rect_union).
module drt_fit
  import drt_pkg::*;
(
  input  rect_t                    slot_rect,
  input  rect_t                    new_rect,
  input  logic signed [AREA_W-1:0] new_area,
  output fit_t                     fit
);

  rect_t                    uni;
  logic signed [AREA_W-1:0] uni_area;
  logic signed [AREA_W-1:0] slot_area;
  logic signed [AREA_W:0]   sum_area;

  assign uni       = rect_union(slot_rect, new_rect);
  assign uni_area  = rect_area(uni);
  assign slot_area = rect_area(slot_rect);
  assign sum_area  = {slot_area[AREA_W-1], slot_area} + {new_area[AREA_W-1], new_area};

  // Merge only when the union costs no more than the two pieces apart.
  assign fit.fits = $signed({uni_area[AREA_W-1], uni_area}) <= sum_area;
  assign fit.uni  = uni;

endmodule

>>> hw/rtl/dirty_rectangle_tracker.sv
// Dirty rectangle tracker: per-tile dirty regions kept in one row memory.
// Depends on drt_pkg, drt_ram and drt_fit.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one transaction per
//   mark or drain. Output channel (out_valid / out_stall / out_data) returns
//   one transaction per mark, and one per dirty slot on a drain (one when the
//   tile was clean); last flags the final one of each input transaction.
//   One transaction is processed at a time. Each tile is one memory row
//   (flag, first commit, all region slots), read once, modified in a
//   register and written back once by a placing mark; a drain clears its
//   valid bit instead. A strip mark loads, places, flags and responds; a
//   body mark loads, scans up to BODY_SLOTS slots, one area test per
//   cycle, places if none fits, flags and responds; a drain loads, then
//   walks up to REGION_SLOTS slots, one per cycle while the output is not
//   stalled, or responds once on a clean tile. A new transaction is taken
//   once the previous one has handed its final result to the output register.
//   Reset: synchronous, active low. Row valid bits and dirty counts clear at
//   once, so every tile reads clean right after reset; no clearing pass.
//   Output stall: the output register holds its transaction; a drain pauses
//   on its next dirty slot until the register frees up.
module dirty_rectangle_tracker
  import drt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  state_t                   state_r, state_nxt;
  in_t                      item_r, item_nxt;
  logic [ROW_AW-1:0]        row_addr_r, row_addr_nxt;
  row_t                     row_r, row_nxt;
  logic signed [AREA_W-1:0] newarea_r, newarea_nxt;
  logic [SLOT_W-1:0]        scan_r, scan_nxt;
  logic                     free_found_r, free_found_nxt;
  logic [SLOT_W-1:0]        free_r, free_nxt;
  logic [SLOT_W-1:0]        written_r, written_nxt;
  logic [SEQ_W-1:0]         oldest_r, oldest_nxt;
  out_t                     res_r, res_nxt;
  logic [CNT_W-1:0]         cnt_r [LEVELS];
  logic [CNT_W-1:0]         cnt_nxt [LEVELS];
  logic [ROWS-1:0]          row_valid_r, row_valid_nxt;
  logic                     out_valid_r;
  out_t                     out_data_r;

  logic                     in_fire;
  logic                     out_free;
  logic                     push;
  out_t                     push_data;
  logic [ROW_AW-1:0]        in_row_addr;
  logic                     item_in_range;
  rect_t                    new_rect;
  rect_t                    cur_slot;
  fit_t                     fit;
  logic [REGION_SLOTS-1:0]  dirty_mask;
  logic                     cur_last;
  logic                     ram_wr_en;
  row_t                     ram_wr_row;
  logic [$bits(row_t)-1:0]  ram_rd_data;
  logic [CNT_W-1:0]         cur_cnt;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_row_addr = ROW_AW'(32'(in_data.level) * TILE_COUNT + 32'(in_data.tile));
  assign item_in_range = (32'(item_r.level) < LEVELS) && (32'(item_r.tile) < TILE_COUNT);

  assign new_rect.dirty = 1'b1;
  assign new_rect.x0    = item_r.rect_x0;
  assign new_rect.y0    = item_r.rect_y0;
  assign new_rect.x1    = item_r.rect_x1;
  assign new_rect.y1    = item_r.rect_y1;

  assign cur_slot = row_r.slots[scan_r];
  assign cur_cnt  = cnt_r[item_r.level];

  always_comb begin
    for (int i = 0; i < REGION_SLOTS; i++) begin
      dirty_mask[i] = row_r.slots[i].dirty;
    end
  end

  // Current slot is the last dirty one when nothing above it is dirty.
  assign cur_last = ((dirty_mask >> scan_r) >> 1) == '0;

  drt_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (ROWS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (row_addr_r),
    .wr_data (ram_wr_row),
    .rd_en   (in_fire),
    .rd_addr (in_row_addr),
    .rd_data (ram_rd_data)
  );

  drt_fit u_fit (
    .slot_rect (cur_slot),
    .new_rect  (new_rect),
    .new_area  (newarea_r),
    .fit       (fit)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (!item_in_range) begin
          state_nxt = ST_RESP;
        end else if (item_r.op == OP_DRAIN) begin
          state_nxt = ST_DRAIN;
        end else if (item_r.target == TGT_NONE) begin
          state_nxt = ST_RESP;
        end else if (item_r.target == TGT_BODY) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_PLACE;
        end
      end
      ST_SCAN: begin
        if (cur_slot.dirty && fit.fits) begin
          state_nxt = ST_FLAG;
        end else if (scan_r == SLOT_W'(BODY_SLOTS - 1)) begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: state_nxt = ST_FLAG;
      ST_FLAG:  state_nxt = ST_RESP;
      ST_DRAIN: begin
        if (!row_r.tdirty || dirty_mask == '0) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cur_slot.dirty) begin
          if (out_free && cur_last) state_nxt = ST_IDLE;
        end else if (scan_r == SLOT_W'(REGION_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    rect_t acc;
    row_t  fin;
    item_nxt       = item_r;
    row_addr_nxt   = row_addr_r;
    row_nxt        = row_r;
    newarea_nxt    = newarea_r;
    scan_nxt       = scan_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    written_nxt    = written_r;
    oldest_nxt     = oldest_r;
    res_nxt        = res_r;
    cnt_nxt        = cnt_r;
    row_valid_nxt  = row_valid_r;
    ram_wr_en      = 1'b0;
    ram_wr_row     = row_r;
    push           = 1'b0;
    push_data      = res_r;
    acc            = row_r.slots[0];
    fin            = row_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          item_nxt     = in_data;
          row_addr_nxt = in_row_addr;
        end
      end
      ST_LOAD: begin
        // A row never written since reset reads as a clean tile.
        row_nxt        = row_valid_r[row_addr_r] ? row_t'(ram_rd_data) : '0;
        newarea_nxt    = rect_area(new_rect);
        scan_nxt       = '0;
        free_found_nxt = 1'b0;
        free_nxt       = '0;
        res_nxt        = '0;
        res_nxt.kind   = (item_r.op == OP_DRAIN) ? KIND_CLEAN : KIND_MARK;
        res_nxt.last   = 1'b1;
        if (item_in_range) begin
          res_nxt.dirty_tiles = cur_cnt;
        end
      end
      ST_SCAN: begin
        if (cur_slot.dirty && fit.fits) begin
          row_nxt.slots[scan_r] = fit.uni;
          written_nxt           = scan_r;
        end else begin
          if (!cur_slot.dirty && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_nxt       = scan_r;
          end
          scan_nxt = scan_r + SLOT_W'(1);
        end
      end
      ST_PLACE: begin
        if (item_r.target != TGT_BODY) begin
          // Grow the strip box, or start it on a clean strip.
          if (item_r.target == TGT_RIGHT) begin
            written_nxt = SLOT_W'(STRIP_RIGHT);
          end else begin
            written_nxt = SLOT_W'(STRIP_BOTTOM);
          end
          if (row_r.slots[written_nxt].dirty) begin
            row_nxt.slots[written_nxt] = rect_union(row_r.slots[written_nxt], new_rect);
          end else begin
            row_nxt.slots[written_nxt] = new_rect;
          end
        end else if (free_found_r) begin
          row_nxt.slots[free_r] = new_rect;
          written_nxt           = free_r;
        end else begin
          // No free body slot: fold every body slot into slot zero.
          acc = rect_union(row_r.slots[0], new_rect);
          for (int i = 1; i < BODY_SLOTS; i++) begin
            acc                  = rect_union(acc, row_r.slots[i]);
            row_nxt.slots[i].dirty = 1'b0;
          end
          row_nxt.slots[0] = acc;
          written_nxt      = '0;
        end
      end
      ST_FLAG: begin
        res_nxt.became_dirty = 1'b0;
        res_nxt.dirty_tiles  = cur_cnt;
        if (!row_r.tdirty) begin
          fin.tdirty                = 1'b1;
          fin.first                 = item_r.commit_number;
          cnt_nxt[item_r.level]     = cur_cnt + CNT_W'(1);
          res_nxt.became_dirty      = 1'b1;
          res_nxt.dirty_tiles       = cur_cnt + CNT_W'(1);
        end
        ram_wr_en                 = 1'b1;
        ram_wr_row                = fin;
        row_valid_nxt[row_addr_r] = 1'b1;
        res_nxt.kind              = KIND_MARK;
        res_nxt.slot              = 3'(written_r);
        res_nxt.out_x0            = fin.slots[written_r].x0;
        res_nxt.out_y0            = fin.slots[written_r].y0;
        res_nxt.out_x1            = fin.slots[written_r].x1;
        res_nxt.out_y1            = fin.slots[written_r].y1;
        res_nxt.oldest_commit     = fin.first;
        res_nxt.last              = 1'b1;
      end
      ST_DRAIN: begin
        if (row_r.tdirty) begin
          // Drop the row: an invalid row reads back as a clean tile.
          row_valid_nxt[row_addr_r] = 1'b0;
          oldest_nxt                = row_r.first;
          if (cur_cnt != '0) begin
            cnt_nxt[item_r.level] = cur_cnt - CNT_W'(1);
            res_nxt.dirty_tiles   = cur_cnt - CNT_W'(1);
          end
          scan_nxt = '0;
        end
      end
      ST_EMIT: begin
        push_data               = '0;
        push_data.kind          = KIND_REGION;
        push_data.slot          = 3'(scan_r);
        push_data.out_x0        = cur_slot.x0;
        push_data.out_y0        = cur_slot.y0;
        push_data.out_x1        = cur_slot.x1;
        push_data.out_y1        = cur_slot.y1;
        push_data.oldest_commit = oldest_r;
        push_data.dirty_tiles   = cur_cnt;
        push_data.last          = cur_last;
        if (cur_slot.dirty) begin
          if (out_free) begin
            push     = 1'b1;
            scan_nxt = scan_r + SLOT_W'(1);
          end
        end else begin
          scan_nxt = scan_r + SLOT_W'(1);
        end
      end
      ST_RESP: begin
        push = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      row_valid_r <= '0;
      for (int l = 0; l < LEVELS; l++) begin
        cnt_r[l] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      row_valid_r <= row_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    row_addr_r   <= row_addr_nxt;
    row_r        <= row_nxt;
    newarea_r    <= newarea_nxt;
    scan_r       <= scan_nxt;
    free_found_r <= free_found_nxt;
    free_r       <= free_nxt;
    written_r    <= written_nxt;
    oldest_r     <= oldest_nxt;
    res_r        <= res_nxt;
    if (push) begin
      out_data_r <= push_data;
    end
  end

`ifndef SYNTHESIS
  // The final result of a transaction returns the block to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_data.last) |=> (state_r == ST_IDLE))
    else $error("final result did not end the transaction");

  // A write-back leaves its row valid.
  a_wb_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |=> row_valid_r[$past(row_addr_r)])
    else $error("written row not marked valid");

  // Draining a dirty tile counts its level down by one.
  a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && row_r.tdirty && cur_cnt != '0)
      |=> (cnt_r[item_r.level] == $past(cur_cnt) - CNT_W'(1)))
    else $error("drain did not decrement dirty tile count");

  // The input side stays stalled while a result is still being produced.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !push_data.last) |-> in_stall)
    else $error("input accepted in the middle of a drain");
`endif

endmodule
